FILE: rtl/core/wzs_pkg.sv
package wzs_pkg;

  // default sizes handed to the top level
  localparam int WZS_MAX_TICKS  = 4096;
  localparam int WZS_PEND_DEPTH = 32;

  // field widths fixed by the item format
  localparam int SAMPLE_W = 16;
  localparam int TICK_W   = 12;
  localparam int MINLEN_W = 5;

  // flush count carried in a command, wide enough for the largest buffer
  localparam int CNT_W = 6;

  // command queue between front and back
  localparam int CMD_DEPTH = 4;
  localparam int CMD_PW    = $clog2(CMD_DEPTH);

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 1'b0,
    REG_RUN_MIN   = 1'b1
  } cfg_reg_t;

  // one command: the live sample plus how many buffered samples precede it
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [TICK_W-1:0]          tick;
    logic [TICK_W-1:0]          run_start;
    logic [CNT_W-1:0]           nflush;
    logic                       bank;
  } cmd_t;

  // buffer bank handed back once its flush is done
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

  typedef enum logic {
    BK_IDLE,
    BK_FLUSH
  } bk_state_t;

endpackage

FILE: rtl/core/wzs_in_if.sv
interface wzs_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               last_tick;

  modport source (output valid, output sample, output last_tick, input ready);
  modport sink   (input valid, input sample, input last_tick, output ready);
endinterface

FILE: rtl/core/wzs_out_if.sv
interface wzs_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] kept_sample;
  logic [11:0]        sample_tick;
  logic [11:0]        run_start;
  logic               burst_last;

  modport source (output valid, output kept_sample, output sample_tick,
                  output run_start, output burst_last, input ready);
  modport sink   (input valid, input kept_sample, input sample_tick,
                  input run_start, input burst_last, output ready);
endinterface

FILE: rtl/core/wzs_pend_ram.sv
module wzs_pend_ram import wzs_pkg::*; #(
  parameter int ADDR_W = 6
) (
  input  logic                clk,
  input  logic                we,
  input  logic [ADDR_W-1:0]   waddr,
  input  logic [SAMPLE_W-1:0] wdata,
  input  logic                re,
  input  logic [ADDR_W-1:0]   raddr,
  output logic [SAMPLE_W-1:0] rdata_r
);

  logic [SAMPLE_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/wzs_cmd_fifo.sv
module wzs_cmd_fifo import wzs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  cmd_t              mem_r [CMD_DEPTH];
  logic [CMD_PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMD_PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMD_PW:0]   count_r, count_nxt;

  assign full  = (count_r == (CMD_PW+1)'(CMD_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("command pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("command popped from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (CMD_PW+1)'(CMD_DEPTH))
    else $error("queue count out of range");

endmodule

FILE: rtl/core/wzs_front.sv
module wzs_front import wzs_pkg::*; #(
  parameter int MAX_TICKS  = WZS_MAX_TICKS,
  parameter int PEND_DEPTH = WZS_PEND_DEPTH,
  localparam int TW = $clog2(MAX_TICKS),
  localparam int PW = $clog2(PEND_DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SAMPLE_W-1:0]  cfg_wdata,
  wzs_in_if.sink               in_ch,
  output logic                 push,
  output cmd_t                 push_cmd,
  input  logic                 q_full,
  input  bank_rel_t            rel,
  output logic                 wr_en,
  output logic [PW:0]          wr_addr,
  output logic [SAMPLE_W-1:0]  wr_data
);

  logic signed [SAMPLE_W-1:0] thr_r;
  logic [MINLEN_W-1:0]        minlen_r;
  logic [TW-1:0]              tick_r, tick_nxt;
  logic                       active_r, active_nxt;
  logic                       kept_r, kept_nxt;
  logic [PW-1:0]              len_r, len_nxt;
  logic [TICK_W-1:0]          begin_r, begin_nxt;
  logic                       bank_r, bank_nxt;
  logic [1:0]                 busy_r, busy_nxt;

  logic [PW-1:0]     eff_min;
  logic [TICK_W-1:0] tick12;
  logic              qual, starting, acc;
  logic              cur_bank, kept_cur;
  logic [PW-1:0]     len_cur;
  logic [TICK_W-1:0] begin_cur;

  always_comb begin
    if (32'(minlen_r) > PEND_DEPTH - 1) begin
      eff_min = PW'(PEND_DEPTH - 1);
    end else begin
      eff_min = PW'(minlen_r);
    end
  end

  assign tick12 = TICK_W'(tick_r);
  assign qual   = (thr_r < 0) ? (in_ch.sample <= thr_r) : (in_ch.sample >= thr_r);

  assign starting  = qual && !active_r;
  assign cur_bank  = starting ? ~bank_r : bank_r;
  assign kept_cur  = starting ? 1'b0 : kept_r;
  assign len_cur   = starting ? '0 : len_r;
  assign begin_cur = starting ? tick12 : begin_r;

  // a new run waits while its bank is still being flushed
  assign in_ch.ready = !q_full && !(starting && busy_r[~bank_r]);
  assign acc         = in_ch.valid && in_ch.ready;

  always_comb begin
    tick_nxt   = tick_r;
    active_nxt = active_r;
    kept_nxt   = kept_r;
    len_nxt    = len_r;
    begin_nxt  = begin_r;
    bank_nxt   = bank_r;
    busy_nxt   = busy_r;
    push       = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = {cur_bank, len_cur};
    wr_data    = in_ch.sample;
    push_cmd.sample    = in_ch.sample;
    push_cmd.tick      = tick12;
    push_cmd.run_start = begin_cur;
    push_cmd.nflush    = '0;
    push_cmd.bank      = cur_bank;

    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end

    if (acc) begin
      if (qual) begin
        active_nxt = 1'b1;
        bank_nxt   = cur_bank;
        begin_nxt  = begin_cur;
        kept_nxt   = kept_cur;
        len_nxt    = len_cur;
        if (kept_cur) begin
          push = 1'b1;
        end else if (len_cur >= eff_min) begin
          push            = 1'b1;
          push_cmd.nflush = CNT_W'(len_cur);
          kept_nxt        = 1'b1;
          if (len_cur != '0) begin
            busy_nxt[cur_bank] = 1'b1;
          end
        end else begin
          wr_en   = 1'b1;
          len_nxt = len_cur + 1'b1;
        end
      end else begin
        active_nxt = 1'b0;
        kept_nxt   = 1'b0;
        len_nxt    = '0;
      end

      if (in_ch.last_tick || tick_r == TW'(MAX_TICKS - 1)) begin
        active_nxt = 1'b0;
        kept_nxt   = 1'b0;
        len_nxt    = '0;
        tick_nxt   = '0;
      end else begin
        tick_nxt = tick_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= '0;
      minlen_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_THRESHOLD: thr_r    <= cfg_wdata;
        REG_RUN_MIN:   minlen_r <= cfg_wdata[MINLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r   <= '0;
      active_r <= 1'b0;
      kept_r   <= 1'b0;
      len_r    <= '0;
      begin_r  <= '0;
      bank_r   <= 1'b1;
      busy_r   <= '0;
    end else begin
      tick_r   <= tick_nxt;
      active_r <= active_nxt;
      kept_r   <= kept_nxt;
      len_r    <= len_nxt;
      begin_r  <= begin_nxt;
      bank_r   <= bank_nxt;
      busy_r   <= busy_nxt;
    end
  end

  a_start_free_bank: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && starting) |-> !busy_r[~bank_r])
    else $error("run started on a bank still being flushed");

  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !busy_r[cur_bank])
    else $error("buffer write into a bank awaiting flush");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> (!kept_r && len_r == '0))
    else $error("run state left over outside a run");

endmodule

FILE: rtl/core/wzs_back.sv
module wzs_back import wzs_pkg::*; #(
  parameter int PEND_DEPTH = WZS_PEND_DEPTH,
  localparam int PW = $clog2(PEND_DEPTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                head,
  input  logic                q_empty,
  output logic                pop,
  output bank_rel_t           rel,
  output logic                rd_en,
  output logic [PW:0]         rd_addr,
  input  logic [SAMPLE_W-1:0] rd_data,
  wzs_out_if.source           out_ch
);

  bk_state_t state_r, state_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic [TICK_W-1:0]          out_tick_r;
  logic [TICK_W-1:0]          out_start_r;
  logic                       out_last_r;

  logic out_free, load_live, load_flush, more;

  assign out_free = !out_valid_r || out_ch.ready;
  assign more     = (k_r != head.nflush);
  assign rd_addr  = {head.bank, k_r[PW-1:0]};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty && more) begin
          state_nxt = BK_FLUSH;
        end
      end
      BK_FLUSH: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    rd_en      = 1'b0;
    load_live  = 1'b0;
    load_flush = 1'b0;
    pop        = 1'b0;
    rel.valid  = 1'b0;
    rel.bank   = head.bank;
    k_nxt      = k_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          if (more) begin
            rd_en = 1'b1;
          end else if (out_free) begin
            load_live = 1'b1;
            pop       = 1'b1;
            k_nxt     = '0;
            rel.valid = (head.nflush != '0);
          end
        end
      end
      BK_FLUSH: begin
        if (out_free) begin
          load_flush = 1'b1;
          k_nxt      = k_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      if (load_live || load_flush) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_live) begin
      out_sample_r <= head.sample;
      out_tick_r   <= head.tick;
      out_start_r  <= head.run_start;
      out_last_r   <= 1'b1;
    end else if (load_flush) begin
      out_sample_r <= rd_data;
      out_tick_r   <= head.run_start + TICK_W'(k_r);
      out_start_r  <= head.run_start;
      out_last_r   <= 1'b0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kept_sample = out_sample_r;
  assign out_ch.sample_tick = out_tick_r;
  assign out_ch.run_start   = out_start_r;
  assign out_ch.burst_last  = out_last_r;

  a_flush_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_FLUSH) |-> (!q_empty && more))
    else $error("flush step beyond command count");

  a_pop_after_flush: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (!more && state_r == BK_IDLE))
    else $error("command retired before its flush finished");

  a_read_then_load: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> (state_r == BK_FLUSH))
    else $error("buffer read without flush step");

endmodule

FILE: rtl/core/waveform_zero_suppression_top.sv
// channel   dir  handshake            payload
// in_ch     in   valid/ready          sample (s16), last_tick
// out_ch    out  valid/ready          kept_sample (s16), sample_tick, run_start, burst_last
// cfg_*     in   cfg_we, no back-off  cfg_index (0 threshold, 1 minimum run), cfg_wdata
//
// one sample accepted per cycle while the command queue has room and no run start waits on its bank
// a live result is loaded into the output register once its command reaches the back end and the output is free
// each buffered sample of a flush goes through a buffer read, then an output load
// a run start stalls input while its buffer bank is still being flushed
// synchronous active-low reset; no clearing pass, buffer contents start undefined
module waveform_zero_suppression_top import wzs_pkg::*; #(
  parameter int MAX_TICKS  = WZS_MAX_TICKS,
  parameter int PEND_DEPTH = WZS_PEND_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SAMPLE_W-1:0]  cfg_wdata,
  wzs_in_if.sink               in_ch,
  wzs_out_if.source            out_ch
);

  localparam int PW = $clog2(PEND_DEPTH);

  // front to queue
  logic push, q_full;
  cmd_t push_cmd;

  // queue to back
  logic pop, q_empty;
  cmd_t head;

  // bank hand-back from back to front
  bank_rel_t rel;

  // pending-sample buffer, two banks so a new run can fill while the last flushes
  logic                wr_en, rd_en;
  logic [PW:0]         wr_addr, rd_addr;
  logic [SAMPLE_W-1:0] wr_data, rd_data;

  // classifies samples, tracks runs, fills the buffer and issues commands
  wzs_front #(
    .MAX_TICKS  (MAX_TICKS),
    .PEND_DEPTH (PEND_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .push      (push),
    .push_cmd  (push_cmd),
    .q_full    (q_full),
    .rel       (rel),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  // short command queue so front and back stall independently
  wzs_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  wzs_pend_ram #(
    .ADDR_W (PW + 1)
  ) u_ram (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_addr),
    .wdata   (wr_data),
    .re      (rd_en),
    .raddr   (rd_addr),
    .rdata_r (rd_data)
  );

  // replays buffered samples then the live one, through a registered output
  wzs_back #(
    .PEND_DEPTH (PEND_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .q_empty (q_empty),
    .pop     (pop),
    .rel     (rel),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .out_ch  (out_ch)
  );

endmodule
